### hw/rtl/gn2d_pkg.sv
// Package for the 2D gradient noise core: fixed-point formats, hash constants,
// the quarter-wave sine table and the gradient lookup function. No dependencies.
`timescale 1ns / 1ps
package gn2d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_BITS = 10;
  localparam int QTR_BITS   = ANGLE_BITS - 2;
  localparam int QTR_SIZE   = 1 << QTR_BITS;

  localparam int OFS_W = FRAC_BITS + 1;  // signed corner offset
  localparam int GRD_W = 17;             // signed Q1.15 gradient component
  localparam int DOT_W = FRAC_BITS + 4;  // signed rounded dot product
  localparam int OUT_W = 18;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  typedef logic [GRD_W-2:0] qsin_tab_t [0:QTR_SIZE];

  function automatic logic [31:0] rot16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // Degree-9 odd polynomial in Q30, every product floored, rounded to Q1.15.
  function automatic qsin_tab_t gen_qsin();
    qsin_tab_t tab;
    longint c [5];
    longint t, t2, p;
    c[0] = 64'sd1686629713;
    c[1] = -64'sd693598669;
    c[2] = 64'sd85569306;
    c[3] = -64'sd5026989;
    c[4] = 64'sd172272;
    for (int i = 0; i <= QTR_SIZE; i++) begin
      t  = longint'(i) <<< (30 - QTR_BITS);
      t2 = (t * t) >>> 30;
      p  = c[4];
      for (int k = 3; k >= 0; k--) begin
        p = c[k] + ((p * t2) >>> 30);
      end
      p = (p * t) >>> 30;
      p = (p + 64'sd16384) >>> 15;
      if (p < 0) p = 0;
      if (p > 32768) p = 32768;
      tab[i] = p[GRD_W-2:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = gen_qsin();

  function automatic logic signed [GRD_W-1:0] sine_of(logic [ANGLE_BITS-1:0] k);
    logic [1:0]          quad;
    logic [QTR_BITS:0]   idx;
    logic signed [GRD_W-1:0] s;
    quad = k[ANGLE_BITS-1 -: 2];
    idx  = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, k[QTR_BITS-1:0]})
                   : {1'b0, k[QTR_BITS-1:0]};
    s = $signed({1'b0, QSIN[idx]});
    return quad[1] ? -s : s;
  endfunction

endpackage

### hw/rtl/gradient_noise_2d_core.sv
// Top level of the 2D gradient noise core: input stage, smoothstep weights,
// corner hashing and gradients, bilinear blend and output rounding.
// Depends on gn2d_pkg, gn2d_hash and gn2d_grad.
//
// Usage: present x_coord_i and y_coord_i (signed Q15.16) with start high; the
// beat is taken at any rising edge where start is high and busy is low. busy
// is always low, so one point can be taken every cycle.
// Each point yields one noise_value_o (signed Q1.16, saturated) with done_o
// high for exactly one cycle. The result of a point passes through nine
// register stages (input, three hash multiplies, gradient lookup, dot
// product, x blend, y blend, output) before it leaves on noise_value_o.
// Throughput is one point per cycle; results leave in the order points came.
// The receiver cannot hold results off, and none is needed: the pipeline
// never stalls. Reset (rst_ni low) clears the valid bits, so points in flight
// are dropped and no strobe follows; the block keeps no other state.
`timescale 1ns / 1ps
module gradient_noise_2d_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [31:0]                 x_coord_i,
  input  logic signed [31:0]                 y_coord_i,
  output logic                               done_o,
  output logic signed [gn2d_pkg::OUT_W-1:0]  noise_value_o
);
  import gn2d_pkg::*;

  localparam int PIPE_DEPTH = 9;
  localparam int F     = FRAC_BITS;
  localparam int TOP_W = F + 6;
  localparam int V_W   = F + 8;
  localparam int RSH   = (F > 16) ? F - 16 : 0;
  localparam int LSH   = (F < 16) ? 16 - F : 0;
  localparam int VR_W  = V_W + LSH + 1;
  localparam logic signed [VR_W-1:0] RND    = (RSH > 0) ? VR_W'(1 << (RSH - 1 + (RSH == 0)))
                                                        : '0;
  localparam logic signed [VR_W-1:0] SAT_HI = VR_W'(131071);
  localparam logic signed [VR_W-1:0] SAT_LO = -VR_W'(131072);

  logic [PIPE_DEPTH-1:0] vld_q;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  // Stage 0: input registers.
  logic signed [31:0] x_q, y_q;
  always_ff @(posedge clk_i) begin
    x_q <= x_coord_i;
    y_q <= y_coord_i;
  end

  // Floor cell index and fraction.
  logic [31:0] x0, y0, x1, y1;
  logic [F-1:0] fx0, fy0;
  assign x0  = 32'(x_q >>> F);
  assign y0  = 32'(y_q >>> F);
  assign x1  = x0 + 32'd1;
  assign y1  = y0 + 32'd1;
  assign fx0 = x_q[F-1:0];
  assign fy0 = y_q[F-1:0];

  // Smoothstep weight, two multiplies over stages 1 and 2.
  logic [F+1:0]   tx, ty;
  logic [2*F+1:0] ux_p, uy_p, hx_p, hy_p;
  logic [F+1:0]   ux_q, uy_q;
  logic [F-1:0]   fx1_q, fy1_q, fx2_q, fy2_q, fx3_q, fy3_q;
  logic [F:0]     hx2_q, hy2_q, hx3_q, hy3_q, hx4_q, hy4_q, hx5_q, hy5_q, hy6_q;

  assign tx   = (F+2)'(3 << F) - {1'b0, fx0, 1'b0};
  assign ty   = (F+2)'(3 << F) - {1'b0, fy0, 1'b0};
  assign ux_p = tx * {2'b00, fx0};
  assign uy_p = ty * {2'b00, fy0};
  assign hx_p = ux_q * {2'b00, fx1_q};
  assign hy_p = uy_q * {2'b00, fy1_q};

  always_ff @(posedge clk_i) begin
    ux_q  <= ux_p[2*F+1:F];
    uy_q  <= uy_p[2*F+1:F];
    fx1_q <= fx0;
    fy1_q <= fy0;
    hx2_q <= hx_p[2*F:F];
    hy2_q <= hy_p[2*F:F];
    fx2_q <= fx1_q;
    fy2_q <= fy1_q;
    hx3_q <= hx2_q;
    hy3_q <= hy2_q;
    fx3_q <= fx2_q;
    fy3_q <= fy2_q;
    hx4_q <= hx3_q;
    hy4_q <= hy3_q;
    hx5_q <= hx4_q;
    hy5_q <= hy4_q;
    hy6_q <= hy5_q;
  end

  // Corner hashes, stages 1 to 3.
  logic [ANGLE_BITS-1:0] ang00, ang10, ang01, ang11;
  gn2d_hash u_hash00 (.clk_i(clk_i), .cx_i(x0), .cy_i(y0), .angle_o(ang00));
  gn2d_hash u_hash10 (.clk_i(clk_i), .cx_i(x1), .cy_i(y0), .angle_o(ang10));
  gn2d_hash u_hash01 (.clk_i(clk_i), .cx_i(x0), .cy_i(y1), .angle_o(ang01));
  gn2d_hash u_hash11 (.clk_i(clk_i), .cx_i(x1), .cy_i(y1), .angle_o(ang11));

  // Offsets to the near and far corners; the far one is the fraction minus one.
  logic signed [OFS_W-1:0] dxa, dxb, dya, dyb;
  assign dxa = $signed({1'b0, fx3_q});
  assign dxb = $signed({1'b1, fx3_q});
  assign dya = $signed({1'b0, fy3_q});
  assign dyb = $signed({1'b1, fy3_q});

  // Gradients and dot products, stages 4 and 5.
  logic signed [DOT_W-1:0] d00, d10, d01, d11;
  gn2d_grad u_grad00 (.clk_i(clk_i), .angle_i(ang00), .dx_i(dxa), .dy_i(dya), .dot_o(d00));
  gn2d_grad u_grad10 (.clk_i(clk_i), .angle_i(ang10), .dx_i(dxb), .dy_i(dya), .dot_o(d10));
  gn2d_grad u_grad01 (.clk_i(clk_i), .angle_i(ang01), .dx_i(dxa), .dy_i(dyb), .dot_o(d01));
  gn2d_grad u_grad11 (.clk_i(clk_i), .angle_i(ang11), .dx_i(dxb), .dy_i(dyb), .dot_o(d11));

  // Stage 6: blend along x.
  logic signed [DOT_W:0]     dtop, dbot;
  logic signed [DOT_W+F+2:0] ptop, pbot;
  logic signed [TOP_W-1:0]   top_q, bot_q;
  assign dtop = (DOT_W+1)'(d10) - (DOT_W+1)'(d00);
  assign dbot = (DOT_W+1)'(d11) - (DOT_W+1)'(d01);
  assign ptop = dtop * $signed({1'b0, hx5_q});
  assign pbot = dbot * $signed({1'b0, hx5_q});

  always_ff @(posedge clk_i) begin
    top_q <= TOP_W'(d00) + $signed(ptop[F+TOP_W-1:F]);
    bot_q <= TOP_W'(d01) + $signed(pbot[F+TOP_W-1:F]);
  end

  // Stage 7: blend along y.
  logic signed [TOP_W:0]     dv;
  logic signed [TOP_W+F+2:0] pv;
  logic signed [V_W-1:0]     v_q;
  assign dv = (TOP_W+1)'(bot_q) - (TOP_W+1)'(top_q);
  assign pv = dv * $signed({1'b0, hy6_q});

  always_ff @(posedge clk_i) begin
    v_q <= V_W'(top_q) + $signed(pv[F+V_W-1:F]);
  end

  // Stage 8: scale to Q1.16, round half up and saturate.
  logic signed [VR_W-1:0] vr;
  logic signed [OUT_W-1:0] out_d, out_q;
  assign vr = ((VR_W'(v_q) + RND) >>> RSH) <<< LSH;

  always_comb begin
    priority if (vr > SAT_HI) begin
      out_d = OUT_W'(SAT_HI);
    end else if (vr < SAT_LO) begin
      out_d = OUT_W'(SAT_LO);
    end else begin
      out_d = vr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o        = vld_q[PIPE_DEPTH-1];
  assign noise_value_o = out_q;

  // Every accepted beat produces its strobe after the fixed pipeline depth.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##PIPE_DEPTH done_o)
    else $error("noise result missing after pipeline latency");

  // A strobe only follows an accepted beat.
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, PIPE_DEPTH)) |-> $past(accept, PIPE_DEPTH))
    else $error("noise strobe without accepted beat");

  // The pipeline never pushes back.
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

endmodule

### hw/rtl/gn2d_hash.sv
// Three-stage multiply and rotate hash of one lattice corner; emits the angle code.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
module gn2d_hash (
  input  logic                           clk_i,
  input  logic [31:0]                    cx_i,
  input  logic [31:0]                    cy_i,
  output logic [gn2d_pkg::ANGLE_BITS-1:0] angle_o
);
  import gn2d_pkg::*;

  logic [31:0] a_q, cy_q, b_q, a2_q;
  logic [31:0] h;
  logic [ANGLE_BITS-1:0] angle_q;

  assign h = (a2_q ^ rot16(b_q)) * HASH_M3;

  always_ff @(posedge clk_i) begin
    a_q     <= cx_i * HASH_M1;
    cy_q    <= cy_i;
    b_q     <= (cy_q ^ rot16(a_q)) * HASH_M2;
    a2_q    <= a_q;
    angle_q <= h[31 -: ANGLE_BITS];
  end

  assign angle_o = angle_q;

endmodule

### hw/rtl/gn2d_grad.sv
// Gradient lookup from the sine table and the rounded dot product with the
// corner offset, two register stages. Depends on gn2d_pkg.
`timescale 1ns / 1ps
module gn2d_grad (
  input  logic                                  clk_i,
  input  logic [gn2d_pkg::ANGLE_BITS-1:0]        angle_i,
  input  logic signed [gn2d_pkg::OFS_W-1:0]      dx_i,
  input  logic signed [gn2d_pkg::OFS_W-1:0]      dy_i,
  output logic signed [gn2d_pkg::DOT_W-1:0]      dot_o
);
  import gn2d_pkg::*;

  localparam int SUM_W = OFS_W + GRD_W + 1;

  logic signed [GRD_W-1:0] gx_q, gy_q;
  logic signed [OFS_W-1:0] dx_q, dy_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [DOT_W-1:0] dot_q;

  assign sum = SUM_W'(dx_q * gx_q) + SUM_W'(dy_q * gy_q) + SUM_W'(1 << 14);

  always_ff @(posedge clk_i) begin
    gx_q  <= sine_of(angle_i);
    gy_q  <= sine_of(angle_i + ANGLE_BITS'(QTR_SIZE));
    dx_q  <= dx_i;
    dy_q  <= dy_i;
    dot_q <= $signed(sum[SUM_W-1:15]);
  end

  assign dot_o = dot_q;

endmodule
